// ===== hdl/addressed_line_assembler_top_defines.svh =====
// assertion macros for the checker file of the line assembler
// no dependencies; taken in by `include where assertions are written
`ifndef ADDRESSED_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define ADDRESSED_LINE_ASSEMBLER_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define ALA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ALA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ala_pkg.sv =====
// shared types and constants of the addressed line assembler
// no dependencies; used by the top level and the checker
package ala_pkg;

  // character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5A;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_ID      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ID = 2'd2;

  // register reset values
  localparam logic       ECHO_RST  = 1'b0;
  localparam logic [7:0] CARD_RST  = 8'd101;
  localparam logic [7:0] BCAST_RST = 8'd42;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ECHO  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] res;
    res = c;
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      res = c + 8'd32;
    end
    return res;
  endfunction

endpackage

// ===== hdl/ala_if.sv =====
// valid/ready channel interfaces for received bytes and result items
// no dependencies beyond the item field widths
interface ala_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

interface ala_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
  modport mon    (input valid, input kind, input data, input last, input ready);
endinterface

// ===== hdl/ala_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ala_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/addressed_line_assembler_top.sv =====
// top level of the addressed line assembler: byte classification, line ram, output register
// depends on ala_pkg, ala_if (ala_in_if, ala_out_if) and ala_ram
//
// Builds a command line from received bytes, one byte per input item. A printable byte or an
// ignored byte does not hold the input; with echo on, a backspace holds the input while its
// three echo bytes leave the output register. With echo on, a line end holds the input while
// CR LF is echoed; when line bytes follow, the input stays held while they are read from the
// line ram and emitted. The drain reads the line ram once per cycle unless the output register
// stalls, and overlaps each read with the hand-off of the previous byte, so the single output
// register and the ram read port set the pace. The line ram has no reset and needs no
// clearing pass: only entries below the fill index are ever read. Input is taken only while
// the block is idle and the output register is empty or being emptied. Configuration writes
// land at once and are meant for idle times.
module addressed_line_assembler_top #(
  parameter int unsigned LINE_CAPACITY = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ala_in_if.sink                              in_ch,
  ala_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [ala_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ala_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // fill index holds at most LINE_CAPACITY-1, so clog2 bits suffice
  localparam int unsigned IDX_W = $clog2(LINE_CAPACITY);
  localparam logic [IDX_W-1:0] STORE_LIMIT = IDX_W'(LINE_CAPACITY - 1);
  localparam logic [IDX_W-1:0] IDX_ONE     = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO     = IDX_W'(2);

  // configuration registers
  logic       echo_r;
  logic [7:0] card_id_r;
  logic [7:0] bcast_id_r;

  // control state
  ala_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] len_r, len_nxt;        // drain end (exclusive)
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;  // next line ram address to read
  logic             rd_pend_r, rd_pend_nxt; // ram read data waits to be sent
  logic             drain_r, drain_nxt;    // line end will emit line bytes
  logic             bs_seq_r, bs_seq_nxt;  // echo sequence is backspace, else CR LF
  logic             phase_r, phase_nxt;    // backspace echo: 0 next space, 1 final BS

  // shadow copies of the first two stored bytes for the prefix check
  logic [7:0] b0_r, b0_nxt;
  logic [7:0] b1_r, b1_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  // line ram ports
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic [7:0]       low_byte;

  // decode of the incoming byte
  logic load_ok;
  logic in_ready;
  logic accept;
  logic is_eol;
  logic is_bs;
  logic is_prt;
  logic has_pfx;
  logic id_match;
  logic line_ok;
  logic [IDX_W-1:0] start_idx;
  logic drain_now;
  logic more;
  logic pop;

  ala_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (low_byte),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign low_byte = ala_pkg::to_lower(in_ch.rx_byte);

  // a new result may be loaded when the output register is free or being taken
  assign load_ok  = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == ala_pkg::S_IDLE) && load_ok;
  assign accept   = in_ch.valid && in_ready;

  assign is_eol = in_ch.rx_byte inside {ala_pkg::CH_CR, ala_pkg::CH_LF};
  assign is_bs  = in_ch.rx_byte inside {ala_pkg::CH_BS, ala_pkg::CH_DEL};
  assign is_prt = (in_ch.rx_byte inside {[ala_pkg::PRINT_LO:ala_pkg::PRINT_HI]})
                  && (fill_r < STORE_LIMIT);

  // address prefix: at least two bytes stored and the second is a colon
  assign has_pfx   = (fill_r >= IDX_TWO) && (b1_r == ala_pkg::CH_COLON);
  assign id_match  = (b0_r == card_id_r) || (b0_r == bcast_id_r);
  assign line_ok   = !has_pfx || id_match;
  assign start_idx = has_pfx ? IDX_TWO : '0;
  assign drain_now = line_ok && (fill_r > start_idx);

  // drain bookkeeping
  assign more = (rd_ptr_r != len_r);
  assign pop  = rd_pend_r && load_ok;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_pend_nxt   = rd_pend_r;
    drain_nxt     = drain_r;
    bs_seq_nxt    = bs_seq_r;
    phase_nxt     = phase_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ala_pkg::S_IDLE: begin
        if (accept) begin
          if (is_eol) begin
            // line end: the line is cleared whatever happens to it
            fill_nxt    = '0;
            len_nxt     = fill_r;
            rd_ptr_nxt  = start_idx;
            rd_pend_nxt = 1'b0;
            drain_nxt   = drain_now;
            if (echo_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ala_pkg::KIND_ECHO;
              out_data_nxt  = ala_pkg::CH_CR;
              out_last_nxt  = 1'b0;
              bs_seq_nxt    = 1'b0;
              phase_nxt     = 1'b0;
              state_nxt     = ala_pkg::S_ECHO;
            end else if (drain_now) begin
              state_nxt = ala_pkg::S_DRAIN;
            end
          end else if (is_bs) begin
            // backspace on an empty line is dropped silently
            if (fill_r != '0) begin
              fill_nxt = fill_r - IDX_ONE;
              if (echo_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ala_pkg::KIND_ECHO;
                out_data_nxt  = ala_pkg::CH_BS;
                out_last_nxt  = 1'b0;
                bs_seq_nxt    = 1'b1;
                phase_nxt     = 1'b0;
                state_nxt     = ala_pkg::S_ECHO;
              end
            end
          end else if (is_prt) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + IDX_ONE;
            if (fill_r == '0) begin
              b0_nxt = low_byte;
            end
            if (fill_r == IDX_ONE) begin
              b1_nxt = low_byte;
            end
            // echo keeps the original case
            if (echo_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ala_pkg::KIND_ECHO;
              out_data_nxt  = in_ch.rx_byte;
              out_last_nxt  = 1'b1;
            end
          end
        end
      end

      ala_pkg::S_ECHO: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ala_pkg::KIND_ECHO;
          if (bs_seq_r) begin
            if (!phase_r) begin
              out_data_nxt = ala_pkg::CH_SP;
              out_last_nxt = 1'b0;
              phase_nxt    = 1'b1;
            end else begin
              out_data_nxt = ala_pkg::CH_BS;
              out_last_nxt = 1'b1;
              state_nxt    = ala_pkg::S_IDLE;
            end
          end else begin
            // LF closes the item unless line bytes follow
            out_data_nxt = ala_pkg::CH_LF;
            out_last_nxt = !drain_r;
            state_nxt    = drain_r ? ala_pkg::S_DRAIN : ala_pkg::S_IDLE;
          end
        end
      end

      ala_pkg::S_DRAIN: begin
        // read one entry ahead; the ram holds its data until the next read
        ram_re = more && (!rd_pend_r || load_ok);
        if (ram_re) begin
          rd_ptr_nxt = rd_ptr_r + IDX_ONE;
        end
        if (pop) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ala_pkg::KIND_LINE;
          out_data_nxt  = ram_rdata;
          out_last_nxt  = !more;
          if (!more) begin
            state_nxt = ala_pkg::S_IDLE;
          end
        end
        rd_pend_nxt = ram_re || (rd_pend_r && !pop);
      end

      default: begin
        state_nxt = ala_pkg::S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ala_pkg::S_IDLE;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      echo_r      <= ala_pkg::ECHO_RST;
      card_id_r   <= ala_pkg::CARD_RST;
      bcast_id_r  <= ala_pkg::BCAST_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ala_pkg::REG_ECHO_ENABLE:  echo_r     <= cfg_wdata[0];
          ala_pkg::REG_CARD_ID:      card_id_r  <= cfg_wdata;
          ala_pkg::REG_BROADCAST_ID: bcast_id_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload and sequencing registers, no reset needed
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    drain_r    <= drain_nxt;
    bs_seq_r   <= bs_seq_nxt;
    phase_r    <= phase_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.data  = out_data_r;
  assign out_ch.last  = out_last_r;

endmodule

// ===== hdl/ala_checker.sv =====
// port-level checker for the addressed line assembler, bound to the top level
// depends on ala_pkg, ala_if and addressed_line_assembler_top_defines.svh
`include "addressed_line_assembler_top_defines.svh"

module ala_checker (
  input logic       clk,
  input logic       rst_n,
  ala_in_if.sink    in_ch,
  ala_out_if.source out_ch
);

  // a stalled result keeps its payload
  `ALA_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data) && $stable(out_ch.kind) && $stable(out_ch.last), "stalled result changed")

  // input is only taken when the output register can take a result
  `ALA_ASSERT(a_in_gated, clk, rst_n, in_ch.ready |-> !out_ch.valid || out_ch.ready, "input taken while output is stalled")

  // line bytes are printable and lower case
  `ALA_ASSERT(a_line_byte, clk, rst_n, out_ch.valid && (out_ch.kind == ala_pkg::KIND_LINE) |-> (out_ch.data >= ala_pkg::PRINT_LO) && (out_ch.data <= ala_pkg::PRINT_HI) && !((out_ch.data >= ala_pkg::UPPER_LO) && (out_ch.data <= ala_pkg::UPPER_HI)), "bad line byte")

  // reset empties the output register
  `ALA_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

bind addressed_line_assembler_top ala_checker u_ala_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
